/* design/tsf_pkg.sv */
// Shared types, limits and codes of the TSO scatter fragmenter.
`timescale 1ns / 1ps
`default_nettype none
package tsf_pkg;
	localparam int MAX_SEGMENTS = 64;
	localparam int MAX_FRAGMENTS = 32;
	localparam int QW = $clog2(MAX_SEGMENTS);
	localparam int SEGW = $clog2(MAX_SEGMENTS + 1);
	localparam int FRAGW = $clog2(MAX_FRAGMENTS + 1);

	localparam logic [1:0] REG_MSS = 2'd0;
	localparam logic [1:0] REG_HDR_LEN = 2'd1;
	localparam logic [1:0] REG_FRAG_SIZE = 2'd2;
	localparam logic [1:0] REG_MAX_DESC = 2'd3;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_SLOTS = 2'd1,
		ERR_CONFIG = 2'd2,
		ERR_DESC = 2'd3
	} err_t;

	typedef logic [QW:0] qptr_t;

	typedef struct packed {
		logic [63:0] seg_addr;
		logic [15:0] seg_len;
		logic seg_first;
		logic seg_last;
		logic [4:0] frag_index;
		logic frag_tso_first;
		logic frag_tso_last;
		logic [15:0] frag_mss_count;
		logic releases_buffer;
		logic [1:0] error_code;
		logic last_of_run;
	} rec_t;

	typedef struct packed {
		logic en;
		logic [QW-1:0] idx;
		rec_t rec;
		qptr_t cp;
	} qwr_t;
endpackage
`default_nettype wire

/* design/tsf_if.sv */
// Handshake channel interfaces for buffers, segment results and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface tsf_in_if;
	logic valid;
	logic ready;
	logic [63:0] buf_addr;
	logic [15:0] buf_len;
	logic is_first;
	logic is_last;
	modport source(output valid, buf_addr, buf_len, is_first, is_last, input ready);
	modport sink(input valid, buf_addr, buf_len, is_first, is_last, output ready);
endinterface

interface tsf_out_if;
	logic valid;
	logic ready;
	logic [63:0] seg_addr;
	logic [15:0] seg_len;
	logic seg_first;
	logic seg_last;
	logic [4:0] frag_index;
	logic frag_tso_first;
	logic frag_tso_last;
	logic [15:0] frag_mss_count;
	logic releases_buffer;
	logic [1:0] error_code;
	logic last_of_run;
	modport source(output valid, seg_addr, seg_len, seg_first, seg_last, frag_index,
		frag_tso_first, frag_tso_last, frag_mss_count, releases_buffer, error_code,
		last_of_run, input ready);
	modport sink(input valid, seg_addr, seg_len, seg_first, seg_last, frag_index,
		frag_tso_first, frag_tso_last, frag_mss_count, releases_buffer, error_code,
		last_of_run, output ready);
endinterface

interface tsf_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/tsf_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the front end.
`timescale 1ns / 1ps
`default_nettype none
module tsf_div
	import tsf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [17:0] dvd,
	input wire logic [13:0] dvs,
	output logic done,
	output logic [17:0] quo
);
	logic busy_q;
	logic [4:0] cnt_q;
	logic [13:0] rem_q;
	logic [17:0] quo_q;
	logic [13:0] dvs_q;
	logic done_q;
	logic [14:0] trial;
	logic take;

	assign trial = {rem_q, quo_q[17]};
	assign take = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd17) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder stays below the divisor, so 14 bits hold it.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dvd;
			dvs_q <= dvs;
		end else if (busy_q) begin
			rem_q <= take ? 14'(trial - {1'b0, dvs_q}) : trial[13:0];
			quo_q <= {quo_q[16:0], take};
		end
	end

	assign done = done_q;
	assign quo = quo_q;
endmodule
`default_nettype wire

/* design/tsf_front.sv */
// Front end: configuration, per-buffer fragmenting and writing results to the queue.
`timescale 1ns / 1ps
`default_nettype none
module tsf_front
	import tsf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	tsf_in_if.sink in_ch,
	tsf_cfg_if.sink cfg_ch,
	input wire qptr_t rd_ptr,
	output qwr_t wr
);
	typedef enum logic [3:0] {
		S_IDLE, S_MDIV, S_MMUL, S_MADD, S_TOP, S_BDIV, S_BMUL, S_BADD,
		S_HEAD, S_PAY, S_PDIV, S_PCHK, S_FIN
	} state_t;

	state_t state_q;
	logic [13:0] mss_q;
	logic [8:0] hdr_q;
	logic [15:0] fsz_q;
	logic [6:0] mdesc_q;
	logic [63:0] hdr_addr_q, addr_q;
	logic [17:0] fill_q, maxmss_q, maxfrag_q, mnum_q, fsize_q;
	logic [17:0] prod_q;
	logic [FRAGW-1:0] frag_q;
	logic [SEGW-1:0] seg_q;
	logic [7:0] sif_q;
	err_t err_q;
	logic tso_f_q, tso_l_q;
	logic [15:0] len_q;
	logic first_q, last_q, hdr_taken_q, open_frag_q, last_pay_q;
	logic pend_v_q;
	rec_t pend_q;
	qptr_t wptr_q, cp_q;
	qwr_t wr_q;
	logic div_go_q;
	logic [17:0] div_dvd_q;
	logic div_done;
	logic [17:0] div_quo;

	logic accept, bad_cfg, fail_now;
	err_t eff_err, fail_code;
	logic [7:0] sif_inc, half_desc;
	logic hc, lp, slots_full;
	logic [17:0] slen, rem, nb;
	logic [15:0] len_after;
	rec_t hrec, err_rec, fin_rec;

	function automatic logic [17:0] begun_dvd(input logic [17:0] fill,
		input logic [13:0] m, input logic [8:0] h);
		logic [18:0] top;
		top = {1'b0, fill} + {5'd0, m} - 19'd1;
		return (top >= {10'd0, h}) ? 18'(top - {10'd0, h}) : 18'd0;
	endfunction

	function automatic rec_t mk_rec(input logic [63:0] a, input logic [17:0] l,
		input logic f, input logic la, input logic [FRAGW-1:0] fi, input logic tf,
		input logic tl, input logic [17:0] mc);
		rec_t r;
		r = '0;
		r.seg_addr = a;
		r.seg_len = l[15:0];
		r.seg_first = f;
		r.seg_last = la;
		r.frag_index = fi[4:0];
		r.frag_tso_first = tf;
		r.frag_tso_last = tl;
		r.frag_mss_count = la ? mc[15:0] : 16'd0;
		return r;
	endfunction

	tsf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .dvd(div_dvd_q), .dvs(mss_q),
		.done(div_done), .quo(div_quo)
	);

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready = (state_q == S_IDLE) && (rd_ptr == cp_q);
	assign accept = in_ch.valid && in_ch.ready;
	assign wr = wr_q;

	always_comb begin
		bad_cfg = (mss_q == 14'd0) || ({1'b0, fsz_q} < {3'd0, mss_q} + {8'd0, hdr_q});
		eff_err = in_ch.is_first ? ERR_NONE : err_q;
		sif_inc = sif_q + 8'd1;
		half_desc = {1'b0, mdesc_q} >> 1;
		slots_full = (frag_q >= FRAGW'(MAX_FRAGMENTS)) || (seg_q >= SEGW'(MAX_SEGMENTS));
		hc = first_q && !hdr_taken_q;
		if (hc) slen = ({2'd0, len_q} < fsize_q) ? {2'd0, len_q} : fsize_q;
		else slen = {9'd0, hdr_q};
		len_after = len_q - slen[15:0];
		if (!hc) len_after = len_q;
		lp = (slen == fsize_q) || (first_q && last_q && len_after == 16'd0);
		hrec = mk_rec(hdr_addr_q, slen, 1'b1, lp, frag_q, first_q && open_frag_q,
			first_q && last_q && len_after == 16'd0, mnum_q);
		rem = (fsize_q > fill_q) ? fsize_q - fill_q : 18'd0;
		nb = (div_quo == 18'd0) ? 18'd1 : div_quo;
		fin_rec = pend_q;
		fin_rec.releases_buffer = last_pay_q || first_q;
		fin_rec.last_of_run = 1'b1;
		fail_now = 1'b0;
		fail_code = ERR_NONE;
		case (state_q)
			S_IDLE: begin
				if (accept && eff_err != ERR_NONE) begin
					fail_now = 1'b1;
					fail_code = eff_err;
				end else if (accept && bad_cfg) begin
					fail_now = 1'b1;
					fail_code = ERR_CONFIG;
				end
			end
			S_TOP, S_PCHK: begin
				fail_now = slots_full;
				fail_code = ERR_SLOTS;
			end
			S_HEAD: begin
				fail_now = (fill_q == 18'd0) && (sif_inc > {1'b0, mdesc_q});
				fail_code = ERR_DESC;
			end
			S_PAY: begin
				if (seg_q >= SEGW'(MAX_SEGMENTS)) begin
					fail_now = 1'b1;
					fail_code = ERR_SLOTS;
				end else if (len_q != 16'd0 && sif_inc > {1'b0, mdesc_q}) begin
					fail_now = 1'b1;
					fail_code = ERR_DESC;
				end
			end
			default: begin
				fail_now = 1'b0;
			end
		endcase
		err_rec = '0;
		err_rec.error_code = fail_code;
		err_rec.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mss_q <= 14'd1460;
			hdr_q <= 9'd54;
			fsz_q <= 16'd65535;
			mdesc_q <= 7'd16;
			hdr_addr_q <= '0;
			fill_q <= '0;
			frag_q <= '0;
			seg_q <= '0;
			sif_q <= '0;
			err_q <= ERR_NONE;
			tso_f_q <= 1'b0;
			tso_l_q <= 1'b0;
			pend_v_q <= 1'b0;
			wptr_q <= '0;
			cp_q <= '0;
			wr_q <= '0;
			div_go_q <= 1'b0;
		end else begin
			wr_q.en <= 1'b0;
			div_go_q <= 1'b0;
			if (cfg_ch.valid) begin
				case (cfg_ch.index)
					REG_MSS: mss_q <= cfg_ch.data[13:0];
					REG_HDR_LEN: hdr_q <= cfg_ch.data[8:0];
					REG_FRAG_SIZE: fsz_q <= cfg_ch.data;
					REG_MAX_DESC: mdesc_q <= cfg_ch.data[6:0];
					default: mss_q <= mss_q;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_q <= in_ch.buf_addr;
						len_q <= in_ch.buf_len;
						first_q <= in_ch.is_first;
						last_q <= in_ch.is_last;
						hdr_taken_q <= 1'b0;
						open_frag_q <= 1'b1;
						last_pay_q <= 1'b0;
						if (in_ch.is_first) begin
							hdr_addr_q <= in_ch.buf_addr;
							fill_q <= '0;
							frag_q <= '0;
							seg_q <= '0;
							sif_q <= '0;
							err_q <= ERR_NONE;
							tso_f_q <= 1'b0;
							tso_l_q <= 1'b0;
						end
						div_go_q <= 1'b1;
						div_dvd_q <= {2'd0, fsz_q - {7'd0, hdr_q}};
						state_q <= S_MDIV;
					end
				end
				S_MDIV: begin
					if (div_done) begin
						maxmss_q <= div_quo;
						state_q <= S_MMUL;
					end
				end
				S_MMUL: begin
					prod_q <= 18'(maxmss_q * mss_q);
					state_q <= S_MADD;
				end
				S_MADD: begin
					maxfrag_q <= prod_q + {9'd0, hdr_q};
					state_q <= S_TOP;
				end
				S_TOP: begin
					if (sif_q > half_desc) begin
						div_go_q <= 1'b1;
						div_dvd_q <= begun_dvd(fill_q, mss_q, hdr_q);
						state_q <= S_BDIV;
					end else begin
						fsize_q <= maxfrag_q;
						mnum_q <= maxmss_q;
						state_q <= S_HEAD;
					end
				end
				S_BDIV: begin
					if (div_done) begin
						mnum_q <= nb;
						state_q <= S_BMUL;
					end
				end
				S_BMUL: begin
					prod_q <= 18'(mnum_q * mss_q);
					state_q <= S_BADD;
				end
				S_BADD: begin
					fsize_q <= prod_q + {9'd0, hdr_q};
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					state_q <= S_PAY;
					if (fill_q == 18'd0) begin
						if (pend_v_q) begin
							wr_q.en <= 1'b1;
							wr_q.idx <= wptr_q[QW-1:0];
							wr_q.rec <= pend_q;
							wptr_q <= wptr_q + qptr_t'(1);
						end
						pend_q <= hrec;
						pend_v_q <= 1'b1;
						last_pay_q <= 1'b0;
						open_frag_q <= 1'b0;
						if (hc) begin
							hdr_taken_q <= 1'b1;
							addr_q <= addr_q + {46'd0, slen};
						end
						len_q <= len_after;
						tso_f_q <= hrec.frag_tso_first;
						tso_l_q <= hrec.frag_tso_last;
						seg_q <= seg_q + SEGW'(1);
						if (slen == fsize_q) begin
							frag_q <= frag_q + FRAGW'(1);
							fill_q <= '0;
							sif_q <= '0;
							state_q <= S_TOP;
						end else begin
							fill_q <= slen;
							sif_q <= sif_inc;
						end
					end
				end
				S_PAY: begin
					if (len_q == 16'd0) begin
						state_q <= S_FIN;
					end else if ({2'd0, len_q} < rem) begin
						if (last_q) tso_l_q <= 1'b1;
						fill_q <= fill_q + {2'd0, len_q};
						seg_q <= seg_q + SEGW'(1);
						sif_q <= sif_inc;
						div_go_q <= 1'b1;
						div_dvd_q <= begun_dvd(fill_q + {2'd0, len_q}, mss_q, hdr_q);
						state_q <= S_PDIV;
					end else begin
						if (pend_v_q) begin
							wr_q.en <= 1'b1;
							wr_q.idx <= wptr_q[QW-1:0];
							wr_q.rec <= pend_q;
							wptr_q <= wptr_q + qptr_t'(1);
						end
						pend_q <= mk_rec(addr_q, rem, 1'b0, 1'b1, frag_q, tso_f_q,
							tso_l_q || (last_q && len_q == rem[15:0]), mnum_q);
						pend_v_q <= 1'b1;
						if (last_q && len_q == rem[15:0]) tso_l_q <= 1'b1;
						len_q <= len_q - rem[15:0];
						addr_q <= addr_q + {46'd0, rem};
						fill_q <= '0;
						sif_q <= '0;
						seg_q <= seg_q + SEGW'(1);
						frag_q <= frag_q + FRAGW'(1);
						last_pay_q <= 1'b1;
						state_q <= S_PCHK;
					end
				end
				S_PDIV: begin
					if (div_done) begin
						if (pend_v_q) begin
							wr_q.en <= 1'b1;
							wr_q.idx <= wptr_q[QW-1:0];
							wr_q.rec <= pend_q;
							wptr_q <= wptr_q + qptr_t'(1);
						end
						pend_q <= mk_rec(addr_q, {2'd0, len_q}, 1'b0, last_q, frag_q,
							tso_f_q, tso_l_q, nb);
						pend_v_q <= 1'b1;
						addr_q <= addr_q + {48'd0, len_q};
						len_q <= '0;
						last_pay_q <= 1'b1;
						state_q <= S_PCHK;
					end
				end
				S_PCHK: begin
					state_q <= (len_q == 16'd0) ? S_FIN : S_TOP;
				end
				S_FIN: begin
					if (pend_v_q) begin
						wr_q.en <= 1'b1;
						wr_q.idx <= wptr_q[QW-1:0];
						wr_q.rec <= fin_rec;
						wptr_q <= wptr_q + qptr_t'(1);
						cp_q <= wptr_q + qptr_t'(1);
						wr_q.cp <= wptr_q + qptr_t'(1);
					end
					pend_v_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// An error drops what the item produced and leaves one error result.
			if (fail_now) begin
				err_q <= fail_code;
				wr_q.en <= 1'b1;
				wr_q.idx <= cp_q[QW-1:0];
				wr_q.rec <= err_rec;
				wr_q.cp <= cp_q + qptr_t'(1);
				cp_q <= cp_q + qptr_t'(1);
				wptr_q <= cp_q + qptr_t'(1);
				pend_v_q <= 1'b0;
				div_go_q <= 1'b0;
				state_q <= S_IDLE;
			end
		end
	end
endmodule
`default_nettype wire

/* design/tsf_back.sv */
// Back end: result queue memory and the registered output stage.
`timescale 1ns / 1ps
`default_nettype none
module tsf_back
	import tsf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire qwr_t wr,
	output qptr_t rd_ptr,
	tsf_out_if.source out_ch
);
	rec_t mem [MAX_SEGMENTS];
	rec_t rdat_q, out_q;
	qptr_t cp_q, rd_q;
	logic rf_q, out_v_q, issue;

	// The commit pointer is taken through a register so that a read never races its write.
	assign issue = !rf_q && (!out_v_q || out_ch.ready) && (rd_q != cp_q);

	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.idx] <= wr.rec;
		if (issue) rdat_q <= mem[rd_q[QW-1:0]];
		if (rf_q) out_q <= rdat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q <= '0;
			rd_q <= '0;
			rf_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			cp_q <= wr.cp;
			rf_q <= issue;
			if (issue) rd_q <= rd_q + qptr_t'(1);
			if (rf_q) out_v_q <= 1'b1;
			else if (out_ch.ready) out_v_q <= 1'b0;
		end
	end

	assign rd_ptr = rd_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.seg_addr = out_q.seg_addr;
	assign out_ch.seg_len = out_q.seg_len;
	assign out_ch.seg_first = out_q.seg_first;
	assign out_ch.seg_last = out_q.seg_last;
	assign out_ch.frag_index = out_q.frag_index;
	assign out_ch.frag_tso_first = out_q.frag_tso_first;
	assign out_ch.frag_tso_last = out_q.frag_tso_last;
	assign out_ch.frag_mss_count = out_q.frag_mss_count;
	assign out_ch.releases_buffer = out_q.releases_buffer;
	assign out_ch.error_code = out_q.error_code;
	assign out_ch.last_of_run = out_q.last_of_run;
endmodule
`default_nettype wire

/* design/tso_scatter_fragmenter.sv */
// Top level of the TSO scatter fragmenter.
`timescale 1ns / 1ps
`default_nettype none
// Cuts the buffers of one segmented send into fragments of segment descriptors.
// A buffer is taken only once every result of the previous buffer has left the
// result queue. Each buffer then needs one 18-step division of the configured
// sizes, and one more for each segment that needs the begun-segment count (a
// fragment past half its descriptor limit, or a payload that ends a fragment
// short), all on the one shared serial divider. Results leave the queue through
// the read and output registers; a read waits while the previous one is still in
// the read register or the receiver stalls. An error yields a single result with
// only error_code and last_of_run set, and repeats until the next first buffer.
module tso_scatter_fragmenter
	import tsf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	tsf_in_if.sink in_ch,
	tsf_out_if.source out_ch,
	tsf_cfg_if.sink cfg_ch
);
	qwr_t wr;
	qptr_t rd_ptr;

	tsf_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .cfg_ch(cfg_ch),
		.rd_ptr(rd_ptr), .wr(wr)
	);

	tsf_back u_back (
		.clk(clk), .arst_n(arst_n), .wr(wr), .rd_ptr(rd_ptr), .out_ch(out_ch)
	);
endmodule
`default_nettype wire

/* verif/tso_scatter_fragmenter_test.sv */
// Self-checking testbench of the TSO scatter fragmenter.
`timescale 1ns / 1ps
module tso_scatter_fragmenter_test;
	import tsf_pkg::*;

	logic clk;
	logic arst_n;
	tsf_in_if in_ch();
	tsf_out_if out_ch();
	tsf_cfg_if cfg_ch();

	tso_scatter_fragmenter u_dut(.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_ch(cfg_ch));

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Shadow of the configuration and of the send state.
	int unsigned sh_mss, sh_hdr, sh_fsize, sh_maxd;
	logic [63:0] st_hdr_addr;
	int unsigned st_fill, st_frags, st_segs, st_segs_frag;
	logic [1:0] st_err;
	logic st_tso_first, st_tso_last;

	rec_t expected_segs[$];
	rec_t item_segs[$];
	int unsigned fail_count;
	int unsigned segs_seen;
	int unsigned items_sent;
	int unsigned errors_seen;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_off_cycles;
	longint unsigned cycle_count;

	function automatic int unsigned begun_count();
		int unsigned top;
		int unsigned n;
		top = st_fill + sh_mss - 1;
		n = (top >= sh_hdr) ? (top - sh_hdr) / sh_mss : 0;
		return (n != 0) ? n : 1;
	endfunction

	function automatic void push_seg(logic [63:0] a, int unsigned len, logic first,
		logic last, int unsigned mcount);
		rec_t r;
		r = '0;
		r.seg_addr = a;
		r.seg_len = len[15:0];
		r.seg_first = first;
		r.seg_last = last;
		r.frag_index = st_frags[4:0];
		r.frag_tso_first = st_tso_first;
		r.frag_tso_last = st_tso_last;
		r.frag_mss_count = last ? mcount[15:0] : 16'd0;
		item_segs.push_back(r);
	endfunction

	function automatic void flag_error(logic [1:0] code);
		rec_t r;
		r = '0;
		st_err = code;
		r.error_code = code;
		r.last_of_run = 1'b1;
		item_segs.delete();
		item_segs.push_back(r);
	endfunction

	// Works out the segments of one buffer into item_segs.
	function automatic void fragment_buffer(logic [63:0] addr_in, int unsigned len_in,
		logic first_buf, logic last_buf);
		logic [63:0] addr;
		int unsigned len, maxmss, maxfrag, fsize, mnum, rem, slen, n;
		logic single, hdr_taken, open_frag, last_payload, lp;
		addr = addr_in;
		len = len_in;
		single = first_buf && last_buf;
		hdr_taken = 0;
		open_frag = 1;
		last_payload = 0;
		item_segs.delete();
		if (first_buf) begin
			st_hdr_addr = addr;
			st_fill = 0;
			st_frags = 0;
			st_segs = 0;
			st_segs_frag = 0;
			st_err = ERR_NONE;
			st_tso_first = 0;
			st_tso_last = 0;
		end
		if (st_err != ERR_NONE) begin
			flag_error(st_err);
			return;
		end
		if (sh_mss == 0 || sh_fsize < sh_mss + sh_hdr) begin
			flag_error(ERR_CONFIG);
			return;
		end
		maxmss = (sh_fsize - sh_hdr) / sh_mss;
		maxfrag = maxmss * sh_mss + sh_hdr;
		forever begin
			fsize = maxfrag;
			mnum = maxmss;
			if (st_frags >= MAX_FRAGMENTS || st_segs >= MAX_SEGMENTS) begin
				flag_error(ERR_SLOTS);
				return;
			end
			if (st_segs_frag > (sh_maxd >> 1)) begin
				mnum = begun_count();
				fsize = mnum * sh_mss + sh_hdr;
			end
			if (st_fill == 0) begin
				if (first_buf && !hdr_taken) begin
					slen = (len < fsize) ? len : fsize;
					hdr_taken = 1;
					len -= slen;
					addr += slen;
				end else begin
					slen = sh_hdr;
				end
				lp = (slen == fsize) || (single && len == 0);
				st_segs_frag++;
				st_tso_first = first_buf && open_frag;
				st_tso_last = single && len == 0;
				st_fill += slen;
				st_segs++;
				open_frag = 0;
				if (st_segs_frag > sh_maxd) begin
					flag_error(ERR_DESC);
					return;
				end
				push_seg(st_hdr_addr, slen, 1, lp, mnum);
				last_payload = 0;
				if (slen == fsize) begin
					st_frags++;
					st_fill = 0;
					st_segs_frag = 0;
					continue;
				end
			end
			if (st_segs >= MAX_SEGMENTS) begin
				flag_error(ERR_SLOTS);
				return;
			end
			if (len == 0)
				break;
			rem = (fsize > st_fill) ? fsize - st_fill : 0;
			st_segs_frag++;
			if (st_segs_frag > sh_maxd) begin
				flag_error(ERR_DESC);
				return;
			end
			if (len < rem) begin
				if (last_buf)
					st_tso_last = 1;
				st_fill += len;
				st_segs++;
				push_seg(addr, len, 0, last_buf, begun_count());
				addr += len;
				len = 0;
			end else begin
				len -= rem;
				if (last_buf && len == 0)
					st_tso_last = 1;
				push_seg(addr, rem, 0, 1, mnum);
				addr += rem;
				st_fill = 0;
				st_segs_frag = 0;
				st_segs++;
				st_frags++;
			end
			last_payload = 1;
			if (st_frags >= MAX_FRAGMENTS || st_segs >= MAX_SEGMENTS) begin
				flag_error(ERR_SLOTS);
				return;
			end
			if (len == 0)
				break;
		end
		n = item_segs.size();
		if (n > 0) begin
			if (last_payload || first_buf)
				item_segs[n - 1].releases_buffer = 1;
			item_segs[n - 1].last_of_run = 1;
		end
	endfunction

	// Valid stays high from one transfer to the next unless the sender idles.
	task automatic send_buffer(logic [63:0] a, logic [15:0] len, logic first_buf,
		logic last_buf);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.buf_addr <= a;
		in_ch.buf_len <= len;
		in_ch.is_first <= first_buf;
		in_ch.is_last <= last_buf;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		fragment_buffer(a, len, first_buf, last_buf);
		foreach (item_segs[k])
			expected_segs.push_back(item_segs[k]);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (expected_segs.size() != 0 || hold_off_cycles != 0)
			@(negedge clk);
		// Buffers with no segments may still be in the divider.
		repeat (200)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value[15:0];
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			REG_MSS: sh_mss = value & 16'h3FFF;
			REG_HDR_LEN: sh_hdr = value & 16'h1FF;
			REG_FRAG_SIZE: sh_fsize = value & 16'hFFFF;
			default: sh_maxd = value & 16'h7F;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(int unsigned m, int unsigned h, int unsigned f, int unsigned d);
		drain_results();
		write_reg(REG_MSS, m);
		write_reg(REG_HDR_LEN, h);
		write_reg(REG_FRAG_SIZE, f);
		write_reg(REG_MAX_DESC, d);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [63:0] rand_addr();
		return {$urandom(), $urandom()};
	endfunction

	// A well-formed send of a few buffers with random contents.
	task automatic send_packet(int unsigned max_len);
		int unsigned nbuf;
		nbuf = $urandom_range(4, 1);
		for (int i = 0; i < nbuf; i++)
			send_buffer(rand_addr(), 16'($urandom_range(max_len)), i == 0, i == nbuf - 1);
	endtask

	task automatic test_directed();
		send_buffer(64'h0, 16'd0, 1, 1);
		send_buffer(64'hFFFF_FFFF_FFFF_FFF0, 16'd200, 1, 1);
		send_buffer(64'h1000, 16'd100, 1, 0);
		send_buffer(64'h2000, 16'd0, 0, 0);
		send_buffer(64'h3000, 16'd3000, 0, 1);
		send_buffer(64'hAAAA_5555_AAAA_5555, 16'hFFFF, 1, 1);
		send_buffer(64'h5555_AAAA_5555_AAAA, 16'd40, 0, 0);
		set_config(100, 20, 450, 4);
		send_buffer(64'h4000, 16'd30, 1, 0);
		send_buffer(64'h5000, 16'd900, 0, 0);
		send_buffer(64'h6000, 16'd777, 0, 1);
		// Out of slots and then the sticky repeat.
		send_buffer(64'h7000, 16'd20000, 1, 0);
		send_buffer(64'h8000, 16'd10, 0, 1);
		set_config(1, 0, 1, 1);
		send_buffer(64'h9000, 16'd5, 1, 1);
		set_config(16383, 511, 65535, 64);
		send_buffer(64'hA000, 16'd600, 1, 0);
		send_buffer(64'hB000, 16'hFFFF, 0, 1);
		set_config(600, 100, 650, 2);
		send_buffer(64'hC000, 16'd50, 1, 1);
		set_config(10, 5, 200, 8);
		send_buffer(64'hD000, 16'd30, 1, 0);
		send_buffer(64'hE000, 16'd3, 0, 0);
		send_buffer(64'hF000, 16'd3, 0, 0);
		send_buffer(64'hF100, 16'd300, 0, 1);
	endtask

	task automatic test_random(int unsigned n_items);
		int unsigned start;
		start = items_sent;
		while (items_sent - start < n_items) begin
			if ($urandom_range(99) < 85)
				send_packet($urandom_range(99) < 80 ? 4000 : 65535);
			else
				send_buffer(rand_addr(), 16'($urandom()), 1'($urandom()), 1'($urandom()));
		end
	endtask

	task automatic test_backpressure();
		hold_off_cycles = 600;
		for (int i = 0; i < 6; i++)
			send_packet(2000);
		drain_results();
	endtask

	// Result checking against the oldest expectation.
	always @(posedge clk) begin
		rec_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			segs_seen++;
			if (out_ch.error_code != ERR_NONE)
				errors_seen++;
			if (expected_segs.size() == 0) begin
				$error("unexpected result seg_len=%0d", out_ch.seg_len);
				fail_count++;
			end else begin
				e = expected_segs.pop_front();
				if (out_ch.seg_addr !== e.seg_addr) begin
					$error("seg_addr exp %h got %h", e.seg_addr, out_ch.seg_addr);
					fail_count++;
				end
				if (out_ch.seg_len !== e.seg_len) begin
					$error("seg_len exp %0d got %0d", e.seg_len, out_ch.seg_len);
					fail_count++;
				end
				if (out_ch.seg_first !== e.seg_first) begin
					$error("seg_first exp %0d got %0d", e.seg_first, out_ch.seg_first);
					fail_count++;
				end
				if (out_ch.seg_last !== e.seg_last) begin
					$error("seg_last exp %0d got %0d", e.seg_last, out_ch.seg_last);
					fail_count++;
				end
				if (out_ch.frag_index !== e.frag_index) begin
					$error("frag_index exp %0d got %0d", e.frag_index, out_ch.frag_index);
					fail_count++;
				end
				if (out_ch.frag_tso_first !== e.frag_tso_first) begin
					$error("frag_tso_first exp %0d got %0d", e.frag_tso_first,
						out_ch.frag_tso_first);
					fail_count++;
				end
				if (out_ch.frag_tso_last !== e.frag_tso_last) begin
					$error("frag_tso_last exp %0d got %0d", e.frag_tso_last,
						out_ch.frag_tso_last);
					fail_count++;
				end
				if (out_ch.frag_mss_count !== e.frag_mss_count) begin
					$error("frag_mss_count exp %0d got %0d", e.frag_mss_count,
						out_ch.frag_mss_count);
					fail_count++;
				end
				if (out_ch.releases_buffer !== e.releases_buffer) begin
					$error("releases_buffer exp %0d got %0d", e.releases_buffer,
						out_ch.releases_buffer);
					fail_count++;
				end
				if (out_ch.error_code !== e.error_code) begin
					$error("error_code exp %0d got %0d", e.error_code, out_ch.error_code);
					fail_count++;
				end
				if (out_ch.last_of_run !== e.last_of_run) begin
					$error("last_of_run exp %0d got %0d", e.last_of_run, out_ch.last_of_run);
					fail_count++;
				end
			end
		end
	end

	// The receiver stalls at random, or holds off entirely while a stretch is counted down.
	always @(negedge clk) begin
		if (hold_off_cycles != 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tso_scatter_fragmenter_test: FAIL");
			$finish;
		end
	end

	initial begin
		cycle_count = 0;
		fail_count = 0;
		segs_seen = 0;
		items_sent = 0;
		errors_seen = 0;
		hold_off_cycles = 0;
		send_idle_pct = 9;
		recv_idle_pct = 68;
		sh_mss = 1460;
		sh_hdr = 54;
		sh_fsize = 65535;
		sh_maxd = 16;
		st_hdr_addr = '0;
		st_fill = 0;
		st_frags = 0;
		st_segs = 0;
		st_segs_frag = 0;
		st_err = ERR_NONE;
		st_tso_first = 0;
		st_tso_last = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.buf_addr = '0;
		in_ch.buf_len = '0;
		in_ch.is_first = 1'b0;
		in_ch.is_last = 1'b0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_MSS;
		cfg_ch.data = '0;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		set_config(1460, 54, 65535, 16);
		test_random(100);
		set_config(100, 40, 1000, 6);
		send_idle_pct = 68;
		recv_idle_pct = 9;
		test_random(100);
		set_config(512, 0, 4096, 64);
		test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(200, 30, 5000, 12);
		test_random(100);
		drain_results();
		$display("Sent %0d buffers, checked %0d results of which %0d carried errors,",
			items_sent, segs_seen, errors_seen);
		$display("over several configurations, backpressure and both idle mixes.");
		if (fail_count == 0 && expected_segs.size() == 0) begin
			$display("tso_scatter_fragmenter_test: PASS");
		end else begin
			$display("tso_scatter_fragmenter_test: FAIL");
		end
		$finish;
	end
endmodule
